>>> rtl/polygon_separating_axis_pushout_top_macros.svh
// ----------------------------------------------------------------------------
// polygon_separating_axis_pushout_top_macros.svh
// Assertion macros shared by the push-out block.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SEPARATING_AXIS_PUSHOUT_TOP_MACROS_SVH
`define POLYGON_SEPARATING_AXIS_PUSHOUT_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define PSAP_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psap: same-cycle check failed");

// next-cycle implication, quiet during reset
`define PSAP_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psap: next-cycle check failed");

`endif

>>> rtl/psap_pkg.sv
// ----------------------------------------------------------------------------
// psap_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psap_pkg;

  localparam int MAX_A_DEF = 16;
  localparam int MAX_B_DEF = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 1'd1;
  localparam logic [31:0] WEIGHT_RST = 32'h0001_0000;
  localparam logic [15:0] TOL_RST    = 16'd1;

  localparam logic [1:0] ST_SEP  = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_FEW  = 2'd2;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int DRAIN_CYCLES = 3;
  localparam int OUT_STEPS    = 8;

  typedef struct packed {
    logic       a_we;
    logic       b_we;
    logic       edge_b;
    logic       cap_cur;
    logic       diff;
    logic       sq_mul;
    logic       sq_init;
    logic       sq_step;
    logic       dv_init;
    logic       dv_step;
    logic       norm;
    logic       proj_clr;
    logic       proj_va;
    logic       proj_vb;
    logic       test_clr;
    logic       eval_pos;
    logic       eval_neg;
    logic       use_best;
    logic       out_emit;
    logic       out_last;
    logic [1:0] status;
  } psap_cmd_t;

  typedef struct packed {
    logic gap;
  } psap_sts_t;

endpackage

>>> rtl/psap_ctrl.sv
// ----------------------------------------------------------------------------
// psap_ctrl
// Sequencer: vertex load, per-edge normal/projection/eval loop, output pass.
// ----------------------------------------------------------------------------
module psap_ctrl #(
  parameter int MAX_A = psap_pkg::MAX_A_DEF,
  parameter int MAX_B = psap_pkg::MAX_B_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       polygon,
  input  logic                       end_of_load,
  output logic                       busy,
  output logic [$clog2(MAX_A)-1:0]   a_waddr,
  output logic [$clog2(MAX_A)-1:0]   a_raddr,
  output logic [$clog2(MAX_B)-1:0]   b_waddr,
  output logic [$clog2(MAX_B)-1:0]   b_raddr,
  output psap_pkg::psap_cmd_t        cmd,
  input  psap_pkg::psap_sts_t        sts,
  output logic                       result_strobe
);
  import psap_pkg::*;

  localparam int AWA = $clog2(MAX_A);
  localparam int AWB = $clog2(MAX_B);
  localparam int CWA = $clog2(MAX_A + 1);
  localparam int CWB = $clog2(MAX_B + 1);
  localparam int CW  = (CWA > CWB) ? CWA : CWB;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_RD0   = 4'd2;
  localparam logic [3:0] S_RD1   = 4'd3;
  localparam logic [3:0] S_DIFF  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SQI   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DVI   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_NORM  = 4'd10;
  localparam logic [3:0] S_PROJ  = 4'd11;
  localparam logic [3:0] S_DRAIN = 4'd12;
  localparam logic [3:0] S_EVAL1 = 4'd13;
  localparam logic [3:0] S_EVAL2 = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]     state, state_next;
  logic [CWA-1:0] a_cnt, a_cnt_next, na, na_next;
  logic [CWB-1:0] b_cnt, b_cnt_next, nb, nb_next;
  logic [CW-1:0]  cur, cur_next, idx, idx_next;
  logic           edge_b, edge_b_next;
  logic [5:0]     iter, iter_next;
  logic [1:0]     status_r, status_next;
  logic           strobe;

  logic [CW-1:0]  na_w, nb_w, n_cur, cur_inc, nxt, nmax, addr_sel, idx_inc;

  assign na_w     = CW'(na);
  assign nb_w     = CW'(nb);
  assign n_cur    = edge_b ? nb_w : na_w;
  assign cur_inc  = cur + CW'(1);
  assign nxt      = (cur_inc == n_cur) ? '0 : cur_inc;
  assign nmax     = (na_w > nb_w) ? na_w : nb_w;
  assign idx_inc  = idx + CW'(1);
  assign addr_sel = (state == S_RD0) ? cur : ((state == S_RD1) ? nxt : idx);

  assign a_raddr = addr_sel[AWA-1:0];
  assign b_raddr = addr_sel[AWB-1:0];
  assign a_waddr = a_cnt[AWA-1:0];
  assign b_waddr = b_cnt[AWB-1:0];

  assign busy          = (state != S_IDLE);
  assign result_strobe = strobe;

  always_comb begin
    state_next  = state;
    a_cnt_next  = a_cnt;
    b_cnt_next  = b_cnt;
    na_next     = na;
    nb_next     = nb;
    cur_next    = cur;
    idx_next    = idx;
    edge_b_next = edge_b;
    iter_next   = iter;
    status_next = status_r;
    cmd         = '0;
    cmd.edge_b  = edge_b;
    cmd.status  = status_r;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (!polygon && (a_cnt < CWA'(MAX_A))) begin
            cmd.a_we   = 1'b1;
            a_cnt_next = a_cnt + CWA'(1);
          end
          if (polygon && (b_cnt < CWB'(MAX_B))) begin
            cmd.b_we   = 1'b1;
            b_cnt_next = b_cnt + CWB'(1);
          end
          if (end_of_load) begin
            na_next    = a_cnt_next;
            nb_next    = b_cnt_next;
            a_cnt_next = '0;
            b_cnt_next = '0;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        idx_next  = '0;
        iter_next = '0;
        if (na == '0) begin
          state_next = S_IDLE;
        end else if ((na < CWA'(3)) || (nb < CWB'(3))) begin
          status_next = ST_FEW;
          state_next  = S_OUT;
        end else begin
          status_next  = ST_PUSH;
          cur_next     = '0;
          edge_b_next  = 1'b0;
          cmd.test_clr = 1'b1;
          state_next   = S_RD0;
        end
      end
      S_RD0: state_next = S_RD1;
      S_RD1: begin
        cmd.cap_cur = 1'b1;
        state_next  = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = S_SQI;
      end
      S_SQI: begin
        cmd.sq_init = 1'b1;
        iter_next   = '0;
        state_next  = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        if (iter == 6'(SQRT_STEPS - 1)) begin
          state_next = S_DVI;
        end else begin
          iter_next = iter + 6'd1;
        end
      end
      S_DVI: begin
        cmd.dv_init = 1'b1;
        iter_next   = '0;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.dv_step = 1'b1;
        if (iter == 6'(DIV_STEPS - 1)) begin
          state_next = S_NORM;
        end else begin
          iter_next = iter + 6'd1;
        end
      end
      S_NORM: begin
        cmd.norm     = 1'b1;
        cmd.proj_clr = 1'b1;
        idx_next     = '0;
        state_next   = S_PROJ;
      end
      S_PROJ: begin
        cmd.proj_va = (idx < na_w);
        cmd.proj_vb = (idx < nb_w);
        if (idx_inc == nmax) begin
          iter_next  = '0;
          state_next = S_DRAIN;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_DRAIN: begin
        if (iter == 6'(DRAIN_CYCLES - 1)) begin
          state_next = S_EVAL1;
        end else begin
          iter_next = iter + 6'd1;
        end
      end
      S_EVAL1: begin
        cmd.eval_pos = 1'b1;
        if (sts.gap) begin
          status_next = ST_SEP;
          idx_next    = '0;
          iter_next   = '0;
          state_next  = S_OUT;
        end else begin
          state_next = S_EVAL2;
        end
      end
      S_EVAL2: begin
        cmd.eval_neg = 1'b1;
        if (cur_inc == n_cur) begin
          cur_next = '0;
          if (edge_b) begin
            idx_next   = '0;
            iter_next  = '0;
            state_next = S_OUT;
          end else begin
            edge_b_next = 1'b1;
            state_next  = S_RD0;
          end
        end else begin
          cur_next   = cur_inc;
          state_next = S_RD0;
        end
      end
      S_OUT: begin
        cmd.use_best = 1'b1;
        if (iter == 6'(OUT_STEPS - 1)) begin
          cmd.out_emit = 1'b1;
          cmd.out_last = (idx_inc == na_w);
          iter_next    = '0;
          if (idx_inc == na_w) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end else begin
          iter_next = iter + 6'd1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      a_cnt    <= '0;
      b_cnt    <= '0;
      na       <= '0;
      nb       <= '0;
      cur      <= '0;
      idx      <= '0;
      edge_b   <= 1'b0;
      iter     <= '0;
      status_r <= ST_SEP;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      a_cnt    <= a_cnt_next;
      b_cnt    <= b_cnt_next;
      na       <= na_next;
      nb       <= nb_next;
      cur      <= cur_next;
      idx      <= idx_next;
      edge_b   <= edge_b_next;
      iter     <= iter_next;
      status_r <= status_next;
      strobe   <= cmd.out_emit;
    end
  end

endmodule

>>> rtl/psap_dp.sv
// ----------------------------------------------------------------------------
// psap_dp
// Vertex stores, edge normal (sqrt + divide), projection pipe, axis
// selection, push and weighting pipe, config registers.
// ----------------------------------------------------------------------------
module psap_dp #(
  parameter int MAX_A = psap_pkg::MAX_A_DEF,
  parameter int MAX_B = psap_pkg::MAX_B_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [psap_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic signed [31:0]                  pos_z,
  input  logic [$clog2(MAX_A)-1:0]            a_waddr,
  input  logic [$clog2(MAX_A)-1:0]            a_raddr,
  input  logic [$clog2(MAX_B)-1:0]            b_waddr,
  input  logic [$clog2(MAX_B)-1:0]            b_raddr,
  input  psap_pkg::psap_cmd_t                 cmd,
  output psap_pkg::psap_sts_t                 sts,
  output logic signed [31:0]                  out_x,
  output logic signed [31:0]                  out_y,
  output logic signed [31:0]                  out_z,
  output logic                                moved,
  output logic [1:0]                          status,
  output logic                                last_vertex
);
  import psap_pkg::*;

  function automatic logic [31:0] sat_w(input logic neg, input logic [52:0] r);
    logic [52:0] rn;
    rn = -r;
    if (neg) begin
      sat_w = (r >= 53'h0_8000_0000) ? 32'h8000_0000 : rn[31:0];
    end else begin
      sat_w = (r > 53'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
  endfunction

  // config
  logic [31:0] weight;
  logic [15:0] tol;
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RST;
      tol    <= TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WEIGHT: weight <= cfg_data;
        CFG_TOL:    tol    <= cfg_data[15:0];
        default:    ;
      endcase
    end
  end

  // vertex stores, registered read
  logic signed [31:0] a_x_mem [MAX_A];
  logic signed [31:0] a_y_mem [MAX_A];
  logic signed [31:0] a_z_mem [MAX_A];
  logic signed [31:0] b_x_mem [MAX_B];
  logic signed [31:0] b_y_mem [MAX_B];
  logic signed [31:0] rd_ax, rd_ay, rd_az, rd_bx, rd_by;

  always_ff @(posedge clk) begin
    if (cmd.a_we) begin
      a_x_mem[a_waddr] <= pos_x;
      a_y_mem[a_waddr] <= pos_y;
      a_z_mem[a_waddr] <= pos_z;
    end
    if (cmd.b_we) begin
      b_x_mem[b_waddr] <= pos_x;
      b_y_mem[b_waddr] <= pos_y;
    end
    rd_ax <= a_x_mem[a_raddr];
    rd_ay <= a_y_mem[a_raddr];
    rd_az <= a_z_mem[a_raddr];
    rd_bx <= b_x_mem[b_raddr];
    rd_by <= b_y_mem[b_raddr];
  end

  // edge vector and reduced magnitudes
  logic signed [31:0] cur_x, cur_y, nx, ny;
  logic signed [32:0] dx, dy;
  logic [32:0]        dxm, dym;
  logic [30:0]        a_r, b_r;
  logic               dx_pos, dy_neg;

  assign nx  = cmd.edge_b ? rd_bx : rd_ax;
  assign ny  = cmd.edge_b ? rd_by : rd_ay;
  assign dx  = 33'(nx) - 33'(cur_x);
  assign dy  = 33'(ny) - 33'(cur_y);
  assign dxm = dx[32] ? 33'(-dx) : dx;
  assign dym = dy[32] ? 33'(-dy) : dy;

  always_ff @(posedge clk) begin
    if (cmd.cap_cur) begin
      cur_x <= nx;
      cur_y <= ny;
    end
    if (cmd.diff) begin
      if (dxm[31] || dym[31]) begin
        a_r <= dxm[31:1];
        b_r <= dym[31:1];
      end else begin
        a_r <= dxm[30:0];
        b_r <= dym[30:0];
      end
      dx_pos <= !dx[32] && (dx != '0);
      dy_neg <= dy[32];
    end
  end

  // length: two bits of radicand per step
  logic [61:0] aa, bb;
  logic [63:0] rad;
  logic [34:0] rem;
  logic [31:0] root;
  logic [36:0] rem_t, trial;

  assign rem_t = {rem, rad[63:62]};
  assign trial = {3'b000, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sq_mul) begin
      aa <= a_r * a_r;
      bb <= b_r * b_r;
    end
    if (cmd.sq_init) begin
      rad  <= 64'(aa) + 64'(bb);
      rem  <= '0;
      root <= '0;
    end else if (cmd.sq_step) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem  <= 35'(rem_t - trial);
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_t[34:0];
        root <= {root[30:0], 1'b0};
      end
    end
  end

  // normal components: restoring divide by length, one bit per step
  logic [33:0] rx, ry, len_x;
  logic [30:0] qx, qy;
  logic signed [31:0] mx, my, ux, uy;

  assign len_x = {2'b00, root};
  assign mx    = $signed({1'b0, qx});
  assign my    = $signed({1'b0, qy});

  always_ff @(posedge clk) begin
    if (cmd.dv_init) begin
      rx <= {3'b000, b_r};
      ry <= {3'b000, a_r};
      qx <= '0;
      qy <= '0;
    end else if (cmd.dv_step) begin
      if (rx >= len_x) begin
        rx <= {34'(rx - len_x)} << 1;
        qx <= {qx[29:0], 1'b1};
      end else begin
        rx <= rx << 1;
        qx <= {qx[29:0], 1'b0};
      end
      if (ry >= len_x) begin
        ry <= {34'(ry - len_x)} << 1;
        qy <= {qy[29:0], 1'b1};
      end else begin
        ry <= ry << 1;
        qy <= {qy[29:0], 1'b0};
      end
    end
    if (cmd.norm) begin
      if (root == '0) begin
        ux <= '0;
        uy <= '0;
      end else begin
        ux <= dy_neg ? -mx : mx;
        uy <= dx_pos ? -my : my;
      end
    end
  end

  // projection pipe (shared with the output pass)
  logic signed [31:0] bux, buy, ux_s, uy_s;
  logic signed [63:0] pax, pay, pbx, pby, pa, pb;
  logic signed [63:0] mina, maxa, minb, maxb;
  logic               va1, va2, va3, vb1, vb2, vb3, have_a, have_b;

  assign ux_s = cmd.use_best ? bux : ux;
  assign uy_s = cmd.use_best ? buy : uy;

  always_ff @(posedge clk) begin
    pax <= rd_ax * ux_s;
    pay <= rd_ay * uy_s;
    pbx <= rd_bx * ux_s;
    pby <= rd_by * uy_s;
    pa  <= pax + pay;
    pb  <= pbx + pby;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va1 <= 1'b0; va2 <= 1'b0; va3 <= 1'b0;
      vb1 <= 1'b0; vb2 <= 1'b0; vb3 <= 1'b0;
      have_a <= 1'b0;
      have_b <= 1'b0;
    end else begin
      va1 <= cmd.proj_va; va2 <= va1; va3 <= va2;
      vb1 <= cmd.proj_vb; vb2 <= vb1; vb3 <= vb2;
      if (cmd.proj_clr) begin
        have_a <= 1'b0;
        have_b <= 1'b0;
      end else begin
        if (va3) have_a <= 1'b1;
        if (vb3) have_b <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (va3) begin
      if (!have_a || (pa < mina)) mina <= pa;
      if (!have_a || (pa > maxa)) maxa <= pa;
    end
    if (vb3) begin
      if (!have_b || (pb < minb)) minb <= pb;
      if (!have_b || (pb > maxb)) maxb <= pb;
    end
  end

  // axis evaluation: +n then -n of the current edge
  logic signed [64:0] d1, d2, best, bmina, bmaxb;
  logic               gap, have_best;

  assign d1      = 65'(maxb) - 65'(mina);
  assign d2      = 65'(maxa) - 65'(minb);
  assign gap     = d1[64] | d2[64];
  assign sts.gap = gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (cmd.test_clr) begin
      have_best <= 1'b0;
    end else if (cmd.eval_pos && !gap) begin
      have_best <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_pos && !gap && (!have_best || (d1 < best))) begin
      best  <= d1;
      bux   <= ux;
      buy   <= uy;
      bmina <= 65'(mina);
      bmaxb <= 65'(maxb);
    end else if (cmd.eval_neg && (d2 < best)) begin
      best  <= d2;
      bux   <= -ux;
      buy   <= -uy;
      bmina <= -65'(maxa);
      bmaxb <= -65'(minb);
    end
  end

  // output pass: contact test, push, weight (address held for the pass)
  logic signed [65:0] diffp, dm, tolv;
  logic               sel_r, negx, negy, negz;
  logic [33:0]        dist_r;
  logic [30:0]        bux_m, buy_m;
  logic [64:0]        offx_p, offy_p;
  logic [34:0]        offx_r, offy_r;
  logic signed [36:0] offx_s, offy_s, ox_r, oy_r, oxn, oyn;
  logic [35:0]        mxa, mya;
  logic [31:0]        mza, azn;
  logic [51:0]        hx, hy, lxf, lyf;
  logic [47:0]        hz, lzf;
  logic [35:0]        lx, ly;
  logic [31:0]        lz;

  assign diffp  = 66'(pa) - 66'(bmina);
  assign dm     = 66'(bmaxb) - 66'(pa);
  assign tolv   = 66'($signed({1'b0, tol, 30'd0}));
  assign bux_m  = bux[31] ? 31'(-bux) : bux[30:0];
  assign buy_m  = buy[31] ? 31'(-buy) : buy[30:0];
  assign offx_p = 65'(bux_m) * 65'(dist_r);
  assign offy_p = 65'(buy_m) * 65'(dist_r);
  assign offx_s = bux[31] ? -$signed({2'b00, offx_r}) : $signed({2'b00, offx_r});
  assign offy_s = buy[31] ? -$signed({2'b00, offy_r}) : $signed({2'b00, offy_r});
  assign oxn    = -ox_r;
  assign oyn    = -oy_r;
  assign azn    = -rd_az;
  assign mxa    = ox_r[36] ? oxn[35:0] : ox_r[35:0];
  assign mya    = oy_r[36] ? oyn[35:0] : oy_r[35:0];
  assign mza    = rd_az[31] ? azn : rd_az;
  assign lxf    = 52'(mxa) * 52'(weight[15:0]);
  assign lyf    = 52'(mya) * 52'(weight[15:0]);
  assign lzf    = 48'(mza) * 48'(weight[15:0]);

  always_ff @(posedge clk) begin
    sel_r  <= (cmd.status == ST_PUSH) && (diffp < tolv);
    dist_r <= (dm > 66'sd0) ? dm[63:30] : '0;
    offx_r <= offx_p[64:30];
    offy_r <= offy_p[64:30];
    ox_r   <= sel_r ? 37'(rd_ax) + offx_s : 37'(rd_ax);
    oy_r   <= sel_r ? 37'(rd_ay) + offy_s : 37'(rd_ay);
    hx     <= 52'(mxa) * 52'(weight[31:16]);
    hy     <= 52'(mya) * 52'(weight[31:16]);
    hz     <= 48'(mza) * 48'(weight[31:16]);
    lx     <= lxf[51:16];
    ly     <= lyf[51:16];
    lz     <= lzf[47:16];
    negx   <= ox_r[36];
    negy   <= oy_r[36];
    negz   <= rd_az[31];
    if (cmd.out_emit) begin
      out_x       <= sat_w(negx, 53'(hx) + 53'(lx));
      out_y       <= sat_w(negy, 53'(hy) + 53'(ly));
      out_z       <= sat_w(negz, 53'(hz) + 53'(lz));
      moved       <= sel_r;
      status      <= cmd.status;
      last_vertex <= cmd.out_last;
    end
  end

endmodule

>>> rtl/polygon_separating_axis_pushout_top.sv
// ----------------------------------------------------------------------------
// polygon_separating_axis_pushout_top
// 2D separating-axis test of polygon A against obstacle B, with push-out of
// the contact vertices of A along the least-penetration axis.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  vertex   | start, busy               | polygon, pos_x/y/z, end_of_load
//  result   | result_strobe (1 cycle)   | out_x/y/z, moved, status, last_vertex
//  config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A vertex is taken on each start while busy is low. The end_of_load vertex starts
// the test: per edge of A and B, a 32-step square root, a 31-step divider
// and one projection per stored vertex, then the output pass over each
// vertex of A. A gap ends the edge loop early.
// Reset is synchronous; it restores weight and tolerance and empties both
// counts. The receiver cannot stall; busy holds off new vertices while the
// test and output pass run.
// ----------------------------------------------------------------------------
`include "polygon_separating_axis_pushout_top_macros.svh"

module polygon_separating_axis_pushout_top #(
  parameter int MAX_A_VERTICES = psap_pkg::MAX_A_DEF,
  parameter int MAX_B_VERTICES = psap_pkg::MAX_B_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // vertex channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            polygon,
  input  logic signed [31:0]              pos_x,
  input  logic signed [31:0]              pos_y,
  input  logic signed [31:0]              pos_z,
  input  logic                            end_of_load,
  // result channel
  output logic                            result_strobe,
  output logic signed [31:0]              out_x,
  output logic signed [31:0]              out_y,
  output logic signed [31:0]              out_z,
  output logic                            moved,
  output logic [1:0]                      status,
  output logic                            last_vertex,
  // config channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import psap_pkg::*;

  localparam int AWA = $clog2(MAX_A_VERTICES);
  localparam int AWB = $clog2(MAX_B_VERTICES);

  psap_cmd_t      cmd;
  psap_sts_t      sts;
  logic [AWA-1:0] a_waddr, a_raddr;
  logic [AWB-1:0] b_waddr, b_raddr;
  logic           cfg_we;

  // config registers always take a transfer; writes must only come while idle, which the block does not enforce
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  psap_ctrl #(
    .MAX_A (MAX_A_VERTICES),
    .MAX_B (MAX_B_VERTICES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .polygon       (polygon),
    .end_of_load   (end_of_load),
    .busy          (busy),
    .a_waddr       (a_waddr),
    .a_raddr       (a_raddr),
    .b_waddr       (b_waddr),
    .b_raddr       (b_raddr),
    .cmd           (cmd),
    .sts           (sts),
    .result_strobe (result_strobe)
  );

  psap_dp #(
    .MAX_A (MAX_A_VERTICES),
    .MAX_B (MAX_B_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .a_waddr     (a_waddr),
    .a_raddr     (a_raddr),
    .b_waddr     (b_waddr),
    .b_raddr     (b_raddr),
    .cmd         (cmd),
    .sts         (sts),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .moved       (moved),
    .status      (status),
    .last_vertex (last_vertex)
  );

  // results are spaced by the multi-cycle output pass
  `PSAP_AST_NXT(a_strobe_single, result_strobe, !result_strobe)
  // a result only follows a cycle of the busy output pass
  `PSAP_AST_IMP(a_strobe_from_pass, result_strobe, $past(busy))
  // the closing vertex always launches the test
  `PSAP_AST_NXT(a_eol_starts_test, start && !busy && end_of_load, busy)
  // moved is only flagged on overlapping results
  `PSAP_AST_IMP(a_moved_only_push, result_strobe && moved, status == ST_PUSH)

endmodule
